/* rtl/mtg_pkg.sv */
// Package for the mesh tangent generator: payload types, codes, FSM states and constants.
package mtg_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TRI  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  localparam logic CFG_DET_THR = 1'b0;
  localparam logic CFG_LEN_THR = 1'b1;

  localparam logic [15:0] DET_THR_RESET = 16'd268;
  localparam logic [15:0] LEN_THR_RESET = 16'd0;

  localparam logic signed [15:0] TAN_ONE = 16'sd16384;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         vertex_index;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         read_index;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic               used_fallback;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } accum_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOAD,
    ST_T_RD,
    ST_T_DET,
    ST_T_NUM,
    ST_T_ACC,
    ST_DIV,
    ST_DIV_DONE,
    ST_R_RD,
    ST_R_LEN,
    ST_R_DOT,
    ST_R_RES,
    ST_R_SHIFT,
    ST_R_SQ,
    ST_R_SQRT,
    ST_R_DIVSET,
    ST_R_OUT
  } state_e;

endpackage

/* rtl/mtg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/mesh_tangent_generator.sv */
// Per-vertex tangent generator: vertex store, tangent accumulators and shared divider.
// One item is worked on at a time; a triangle whose determinant is at or under the threshold is
// skipped, and code 3 is taken without leaving idle. The shared divider, run three times per
// triangle and per read, gives 32 quotient bits; the square root has 32 steps.
// Reset clears the sequencer, the result valid flag and the thresholds (268 and 0). The vertex
// and accumulator memories are not cleared and hold garbage until a vertex is loaded.
module mesh_tangent_generator
  import mtg_pkg::*;
#(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = $clog2(VERTEX_COUNT);

  // Sequencer state. Every state steps cnt_q from zero; comp_q walks the three components.
  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] comp_q;
  logic       fb_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic [15:0] det_thr_q, len_thr_q;

  // Item registers. The three indices are reduced modulo the store depth in place.
  in_item_t   item_q;
  logic [9:0] idx_q [3];
  vertex_t    vtx_q [3];

  // Shared multiplier with a registered product, and the running sum behind it.
  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] prod_q;
  logic signed [67:0] sum_q;
  logic signed [67:0] fin_add, fin_sub;

  // Triangle values.
  logic signed [35:0] det_q, det_d;
  logic [35:0]        det_mag_q, det_mag_d;
  logic signed [31:0] t_q [3];

  // Read values.
  logic signed [31:0] a_q [3];
  logic signed [15:0] n_q [3];
  logic signed [34:0] dot12_q;
  logic signed [35:0] r_q [3];
  logic [34:0]        m_q [3];
  logic signed [15:0] tan_q [3];
  logic [2:0]         shift_amt;

  // Square root.
  logic [63:0] sq_x_q, sq_res_q, sq_res_d, sq_x_d, sq_bit, sq_trial;
  logic [5:0]  sq_sh;

  // Shared restoring divider: a 59-bit dividend over a 36-bit divisor, 32 quotient bits.
  logic [58:0] div_a_in;
  logic [35:0] div_b_in;
  logic        div_neg_in;
  logic        div_load;
  logic [36:0] div_rem_q, div_rem2;
  logic [35:0] div_b_q;
  logic [31:0] div_sh_q, div_quo_q;
  logic        div_ovf_q, div_neg_q, div_ge;

  // Memory ports.
  logic          vram_we, aram_we;
  logic [AW-1:0] vram_waddr, vram_raddr, aram_waddr, aram_raddr;
  vertex_t       vram_wdata, vram_rdata;
  accum_t        aram_wdata, aram_rdata;

  // Decisions that the next-state logic needs.
  logic tri_skip, len_pass, sqrt_zero;
  logic [1:0] lane;
  logic [1:0] corner;

  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [24:0] e1 [3];
  logic signed [24:0] e2 [3];
  logic signed [43:0] num_d;
  logic [43:0]        num_mag;

  function automatic logic [AW-1:0] to_addr(input logic [9:0] idx);
    return AW'(idx);
  endfunction

  function automatic logic [32:0] mag32(input logic signed [31:0] v);
    return v[31] ? 33'(-(33'(v))) : 33'(v);
  endfunction

  // Divide by 2^14, rounding half away from zero.
  function automatic logic signed [67:0] rnd14(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] q;
    m = v[67] ? 68'(-v) : 68'(v);
    q = (m + 68'd8192) >> 14;
    return v[67] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) + 33'(y);
    if (s > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(s);
  endfunction

  assign lane   = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];
  assign corner = (cnt_q[2:1] == 2'd3) ? 2'd2 : cnt_q[2:1];

  assign du1 = $signed({vtx_q[1].tex_u[15], vtx_q[1].tex_u})
             - $signed({vtx_q[0].tex_u[15], vtx_q[0].tex_u});
  assign dv1 = $signed({vtx_q[1].tex_v[15], vtx_q[1].tex_v})
             - $signed({vtx_q[0].tex_v[15], vtx_q[0].tex_v});
  assign du2 = $signed({vtx_q[2].tex_u[15], vtx_q[2].tex_u})
             - $signed({vtx_q[0].tex_u[15], vtx_q[0].tex_u});
  assign dv2 = $signed({vtx_q[2].tex_v[15], vtx_q[2].tex_v})
             - $signed({vtx_q[0].tex_v[15], vtx_q[0].tex_v});

  always_comb begin
    e1[0] = 25'(vtx_q[1].pos_x) - 25'(vtx_q[0].pos_x);
    e1[1] = 25'(vtx_q[1].pos_y) - 25'(vtx_q[0].pos_y);
    e1[2] = 25'(vtx_q[1].pos_z) - 25'(vtx_q[0].pos_z);
    e2[0] = 25'(vtx_q[2].pos_x) - 25'(vtx_q[0].pos_x);
    e2[1] = 25'(vtx_q[2].pos_y) - 25'(vtx_q[0].pos_y);
    e2[2] = 25'(vtx_q[2].pos_z) - 25'(vtx_q[0].pos_z);
  end

  // The last product of a multiply sequence arrives in the cycle after it was issued and is
  // folded in here rather than in sum_q.
  assign fin_add = sum_q + prod_q;
  assign fin_sub = sum_q - prod_q;

  assign det_d     = 36'(fin_sub);
  assign det_mag_d = det_d[35] ? 36'(-det_d) : 36'(det_d);
  assign tri_skip  = (det_mag_d <= 36'(det_thr_q));
  assign len_pass  = (sum_q > prod_q);

  assign num_d   = 44'(fin_sub);
  assign num_mag = num_d[43] ? 44'(-num_d) : 44'(num_d);

  // One square-root step: compare against the trial value, then shift the root.
  assign sq_sh    = 6'd62 - {cnt_q[4:0], 1'b0};
  assign sq_bit   = 64'd1 << sq_sh;
  assign sq_trial = sq_res_q + sq_bit;
  always_comb begin
    if (sq_x_q >= sq_trial) begin
      sq_x_d   = sq_x_q - sq_trial;
      sq_res_d = (sq_res_q >> 1) + sq_bit;
    end else begin
      sq_x_d   = sq_x_q;
      sq_res_d = sq_res_q >> 1;
    end
  end
  assign sqrt_zero = (sq_res_d == 64'd0);

  // Normalization shift that brings every residue magnitude below 2^30.
  always_comb begin
    logic [34:0] m_or;
    m_or = m_q[0] | m_q[1] | m_q[2];
    if (m_or[34]) begin
      shift_amt = 3'd5;
    end else if (m_or[33]) begin
      shift_amt = 3'd4;
    end else if (m_or[32]) begin
      shift_amt = 3'd3;
    end else if (m_or[31]) begin
      shift_amt = 3'd2;
    end else if (m_or[30]) begin
      shift_amt = 3'd1;
    end else begin
      shift_amt = 3'd0;
    end
  end

  assign div_rem2 = {div_rem_q[35:0], div_sh_q[31]};
  assign div_ge   = (div_rem2 >= {1'b0, div_b_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (item_func_ok(in_i.func))) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (cnt_q == 6'd9) begin
          unique case (item_q.func)
            FUNC_LOAD: state_d = ST_LOAD;
            FUNC_TRI:  state_d = ST_T_RD;
            FUNC_READ: state_d = ST_R_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:     state_d = ST_IDLE;
      ST_T_RD:     if (cnt_q == 6'd3) state_d = ST_T_DET;
      ST_T_DET: begin
        if (cnt_q == 6'd2) begin
          state_d = tri_skip ? ST_IDLE : ST_T_NUM;
        end
      end
      ST_T_NUM:    if (cnt_q == 6'd2) state_d = ST_DIV;
      ST_DIV:      if (cnt_q == 6'd31) state_d = ST_DIV_DONE;
      ST_DIV_DONE: begin
        if (item_q.func == FUNC_TRI) begin
          state_d = (comp_q == 2'd2) ? ST_T_ACC : ST_T_NUM;
        end else begin
          state_d = (comp_q == 2'd2) ? ST_R_OUT : ST_R_DIVSET;
        end
      end
      ST_T_ACC:    if (cnt_q == 6'd5) state_d = ST_IDLE;
      ST_R_RD:     if (cnt_q == 6'd1) state_d = ST_R_LEN;
      ST_R_LEN: begin
        if (cnt_q == 6'd4) begin
          state_d = len_pass ? ST_R_DOT : ST_R_OUT;
        end
      end
      ST_R_DOT:    if (cnt_q == 6'd3) state_d = ST_R_RES;
      ST_R_RES:    if (cnt_q == 6'd3) state_d = ST_R_SHIFT;
      ST_R_SHIFT:  state_d = ST_R_SQ;
      ST_R_SQ:     if (cnt_q == 6'd3) state_d = ST_R_SQRT;
      ST_R_SQRT: begin
        if (cnt_q == 6'd31) begin
          state_d = sqrt_zero ? ST_R_OUT : ST_R_DIVSET;
        end
      end
      ST_R_DIVSET: state_d = ST_DIV;
      ST_R_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
    cnt_d = (state_d != state_q) ? 6'd0 : cnt_q + 6'd1;
  end

  function automatic logic item_func_ok(input logic [1:0] f);
    return f != FUNC_NOP;
  endfunction

  // Outputs of the sequencer: multiplier operands, memory ports and divider loading.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    vram_we    = 1'b0;
    vram_waddr = to_addr(idx_q[0]);
    vram_wdata = '{pos_x: item_q.pos_x, pos_y: item_q.pos_y, pos_z: item_q.pos_z,
                   norm_x: item_q.norm_x, norm_y: item_q.norm_y, norm_z: item_q.norm_z,
                   tex_u: item_q.tex_u, tex_v: item_q.tex_v};
    vram_raddr = to_addr(idx_q[0]);
    aram_we    = 1'b0;
    aram_waddr = to_addr(idx_q[corner]);
    aram_wdata = '0;
    aram_raddr = to_addr(idx_q[0]);
    div_load   = 1'b0;
    div_a_in   = '0;
    div_b_in   = '0;
    div_neg_in = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        vram_we    = 1'b1;
        aram_we    = 1'b1;
        aram_waddr = to_addr(idx_q[0]);
      end
      ST_T_RD: begin
        vram_raddr = to_addr(idx_q[lane]);
      end
      ST_T_DET: begin
        if (cnt_q == 6'd0) begin
          mul_a = 35'(du1);
          mul_b = 33'(dv2);
        end else begin
          mul_a = 35'(du2);
          mul_b = 33'(dv1);
        end
      end
      ST_T_NUM: begin
        if (cnt_q == 6'd0) begin
          mul_a = 35'(e1[comp_q]);
          mul_b = 33'(dv2);
        end else begin
          mul_a = 35'(e2[comp_q]);
          mul_b = 33'(dv1);
        end
        if (cnt_q == 6'd2) begin
          div_load   = 1'b1;
          div_a_in   = {num_mag[42:0], 15'd0} + 59'(det_mag_q);
          div_b_in   = {det_mag_q[34:0], 1'b0};
          div_neg_in = num_d[43] != det_q[35];
        end
      end
      ST_T_ACC: begin
        aram_raddr = to_addr(idx_q[corner]);
        if (cnt_q[0]) begin
          aram_we    = 1'b1;
          aram_wdata = '{x: sat_add(aram_rdata.x, t_q[0]),
                         y: sat_add(aram_rdata.y, t_q[1]),
                         z: sat_add(aram_rdata.z, t_q[2])};
        end
      end
      ST_R_LEN: begin
        if (cnt_q == 6'd3) begin
          mul_a = $signed(35'(len_thr_q));
          mul_b = $signed(33'(len_thr_q));
        end else begin
          mul_a = $signed(35'(mag32(a_q[lane])));
          mul_b = $signed(mag32(a_q[lane]));
        end
      end
      ST_R_DOT: begin
        mul_a = 35'(a_q[lane]);
        mul_b = 33'(n_q[lane]);
      end
      ST_R_RES: begin
        mul_a = dot12_q;
        mul_b = 33'(n_q[lane]);
      end
      ST_R_SQ: begin
        mul_a = $signed(m_q[lane]);
        mul_b = $signed(33'(m_q[lane]));
      end
      ST_R_DIVSET: begin
        div_load   = 1'b1;
        div_a_in   = {9'd0, m_q[comp_q][29:0], 15'd0} + 59'(sq_res_q[31:0]);
        div_b_in   = {3'd0, sq_res_q[31:0], 1'b0};
        div_neg_in = r_q[comp_q][35];
      end
      default: begin
      end
    endcase
  end

  mtg_ram #(
    .WIDTH ($bits(vertex_t)),
    .DEPTH (VERTEX_COUNT)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  mtg_ram #(
    .WIDTH ($bits(accum_t)),
    .DEPTH (VERTEX_COUNT)
  ) u_accum_ram (
    .clk_i   (clk_i),
    .we_i    (aram_we),
    .waddr_i (aram_waddr),
    .wdata_i (aram_wdata),
    .raddr_i (aram_raddr),
    .rdata_o (aram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      fb_q        <= 1'b0;
      out_valid_q <= 1'b0;
      det_thr_q   <= DET_THR_RESET;
      len_thr_q   <= LEN_THR_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DET_THR: det_thr_q <= cfg_data_i;
          CFG_LEN_THR: len_thr_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == ST_IDLE) begin
        fb_q   <= 1'b0;
        comp_q <= '0;
      end
      if (state_q == ST_R_LEN && cnt_q == 6'd4 && !len_pass) begin
        fb_q <= 1'b1;
      end
      if (state_q == ST_R_SQRT && cnt_q == 6'd31 && sqrt_zero) begin
        fb_q <= 1'b1;
      end
      if (state_q == ST_DIV_DONE) begin
        comp_q <= comp_q + 2'd1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_R_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cnt_q == 6'd1) begin
      sum_q <= prod_q;
    end else begin
      sum_q <= fin_add;
    end

    if (div_load) begin
      div_rem_q <= {10'd0, div_a_in[58:32]};
      div_sh_q  <= div_a_in[31:0];
      div_b_q   <= div_b_in;
      div_ovf_q <= ({10'd0, div_a_in[58:32]} >= {1'b0, div_b_in});
      div_neg_q <= div_neg_in;
    end else if (state_q == ST_DIV) begin
      div_rem_q <= div_ge ? div_rem2 - {1'b0, div_b_q} : div_rem2;
      div_sh_q  <= {div_sh_q[30:0], 1'b0};
      div_quo_q <= {div_quo_q[30:0], div_ge};
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_q   <= in_i;
          idx_q[0] <= in_i.vertex_index;
          idx_q[1] <= in_i.corner_b;
          idx_q[2] <= in_i.corner_c;
        end
      end
      ST_MOD: begin
        for (int k = 0; k < 3; k++) begin
          logic [31:0] lim;
          lim = 32'(VERTEX_COUNT) << (4'd9 - cnt_q[3:0]);
          if (32'(idx_q[k]) >= lim) begin
            idx_q[k] <= idx_q[k] - 10'(lim);
          end
        end
      end
      ST_T_RD: begin
        if (cnt_q != 6'd0) begin
          vtx_q[cnt_q[1:0] - 2'd1] <= vram_rdata;
        end
      end
      ST_T_DET: begin
        if (cnt_q == 6'd2) begin
          det_q     <= det_d;
          det_mag_q <= det_mag_d;
        end
      end
      ST_DIV_DONE: begin
        if (item_q.func == FUNC_TRI) begin
          if (div_neg_q) begin
            t_q[comp_q] <= (div_ovf_q || div_quo_q > 32'h80000000) ? 32'sh80000000
                                                                    : -$signed(div_quo_q);
          end else begin
            t_q[comp_q] <= (div_ovf_q || div_quo_q[31]) ? 32'sh7fffffff
                                                         : $signed(div_quo_q);
          end
        end else begin
          logic [15:0] q15;
          q15 = (div_ovf_q || div_quo_q > 32'd32767) ? 16'd32767 : {1'b0, div_quo_q[14:0]};
          tan_q[comp_q] <= div_neg_q ? -$signed(q15) : $signed(q15);
        end
      end
      ST_R_RD: begin
        if (cnt_q == 6'd1) begin
          a_q[0] <= aram_rdata.x;
          a_q[1] <= aram_rdata.y;
          a_q[2] <= aram_rdata.z;
          n_q[0] <= vram_rdata.norm_x;
          n_q[1] <= vram_rdata.norm_y;
          n_q[2] <= vram_rdata.norm_z;
        end
      end
      ST_R_DOT: begin
        if (cnt_q == 6'd3) begin
          dot12_q <= 35'(rnd14(fin_add));
        end
      end
      ST_R_RES: begin
        if (cnt_q != 6'd0) begin
          logic signed [35:0] r;
          r = 36'(a_q[cnt_q[1:0] - 2'd1]) - 36'(rnd14(prod_q));
          r_q[cnt_q[1:0] - 2'd1] <= r;
          m_q[cnt_q[1:0] - 2'd1] <= r[35] ? 35'(-r) : 35'(r);
        end
      end
      ST_R_SHIFT: begin
        for (int k = 0; k < 3; k++) begin
          m_q[k] <= m_q[k] >> shift_amt;
        end
      end
      ST_R_SQ: begin
        if (cnt_q == 6'd3) begin
          sq_x_q   <= 64'(fin_add);
          sq_res_q <= '0;
        end
      end
      ST_R_SQRT: begin
        sq_x_q   <= sq_x_d;
        sq_res_q <= sq_res_d;
      end
      ST_R_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.read_index    <= item_q.vertex_index;
          out_q.used_fallback <= fb_q;
          out_q.tan_x         <= fb_q ? TAN_ONE : tan_q[0];
          out_q.tan_y         <= fb_q ? 16'sd0 : tan_q[1];
          out_q.tan_z         <= fb_q ? 16'sd0 : tan_q[2];
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  // A working item closes the input until the sequencer is back in idle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.func != FUNC_NOP) |=> !in_ready_o)
    else $error("input still ready after a working item was accepted");

  // A new result beat appears only out of the result state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_R_OUT)
    else $error("result beat raised outside the result state");

  // A fallback beat always carries the unit x axis.
  a_fallback_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.used_fallback) |->
      (out_o.tan_x == TAN_ONE && out_o.tan_y == 16'sd0 && out_o.tan_z == 16'sd0))
    else $error("fallback beat without the unit x tangent");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the mesh tangent generator: directed and random beats checked against a predictor.
module tb_top;
  import mtg_pkg::*;

  localparam int NVERT = 1024;
  localparam int STALL_LIMIT = 20000;

  // The scoreboard keeps its own copy of the vertex store, the tangent sums and
  // the thresholds. Every accepted input beat runs through the tangent predictor,
  // and every read leaves one expected tangent in the queue.
  class tangent_scoreboard;
    vertex_t     verts[NVERT];
    longint      sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
    logic [15:0] det_thr, len_thr;
    out_item_t   want_q[$];
    int          errors;

    function new();
      det_thr = DET_THR_RESET;
      len_thr = LEN_THR_RESET;
      errors  = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == CFG_DET_THR) det_thr = val;
      else len_thr = val;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Round half away from zero for a right shift and for a division.
    function longint shift_round(longint v, int k);
      longint unsigned q;
      q = (mag(v) + (64'd1 << (k - 1))) >> k;
      return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint div_round(longint num, longint den);
      longint unsigned n, d, q;
      n = mag(num);
      d = mag(den);
      q = (2 * n + d) / (2 * d);
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    function void add_triangle(int a, int b, int c);
      longint du1, dv1, du2, dv2, det, num;
      longint e1[3], e2[3], t[3];
      int     corner[3];
      du1 = longint'(verts[b].tex_u) - longint'(verts[a].tex_u);
      dv1 = longint'(verts[b].tex_v) - longint'(verts[a].tex_v);
      du2 = longint'(verts[c].tex_u) - longint'(verts[a].tex_u);
      dv2 = longint'(verts[c].tex_v) - longint'(verts[a].tex_v);
      det = du1 * dv2 - du2 * dv1;
      if (mag(det) <= longint'(det_thr)) return;
      e1[0] = longint'(verts[b].pos_x) - longint'(verts[a].pos_x);
      e1[1] = longint'(verts[b].pos_y) - longint'(verts[a].pos_y);
      e1[2] = longint'(verts[b].pos_z) - longint'(verts[a].pos_z);
      e2[0] = longint'(verts[c].pos_x) - longint'(verts[a].pos_x);
      e2[1] = longint'(verts[c].pos_y) - longint'(verts[a].pos_y);
      e2[2] = longint'(verts[c].pos_z) - longint'(verts[a].pos_z);
      for (int k = 0; k < 3; k++) begin
        num = dv2 * e1[k] - dv1 * e2[k];
        t[k] = sat32(div_round(num * 16384, det));
      end
      corner = '{a, b, c};
      foreach (corner[j]) begin
        sum_x[corner[j]] = sat32(sum_x[corner[j]] + t[0]);
        sum_y[corner[j]] = sat32(sum_y[corner[j]] + t[1]);
        sum_z[corner[j]] = sat32(sum_z[corner[j]] + t[2]);
      end
    endfunction

    // Gram-Schmidt against the stored normal, then normalize to Q2.14.
    function out_item_t finish_tangent(int v);
      out_item_t       o;
      longint          a[3], n[3], r[3], dot;
      longint unsigned m[3], sq, len, q;
      int              s;
      a = '{sum_x[v], sum_y[v], sum_z[v]};
      n = '{longint'(verts[v].norm_x), longint'(verts[v].norm_y), longint'(verts[v].norm_z)};
      o.read_index = v[9:0];
      o.tan_x = TAN_ONE;
      o.tan_y = '0;
      o.tan_z = '0;
      o.used_fallback = 1'b1;
      sq = 0;
      for (int i = 0; i < 3; i++) sq += mag(a[i]) * mag(a[i]);
      if (sq <= longint'(len_thr) * longint'(len_thr)) return o;
      dot = 0;
      for (int i = 0; i < 3; i++) dot += n[i] * a[i];
      dot = shift_round(dot, 14);
      for (int i = 0; i < 3; i++) begin
        r[i] = a[i] - shift_round(n[i] * dot, 14);
        m[i] = mag(r[i]);
      end
      s = 0;
      while ((m[0] >> s) >= (64'd1 << 30) || (m[1] >> s) >= (64'd1 << 30) ||
             (m[2] >> s) >= (64'd1 << 30)) s++;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] >>= s;
        sq += m[i] * m[i];
      end
      len = int_sqrt(sq);
      if (len == 0) return o;
      for (int i = 0; i < 3; i++) begin
        q = (2 * (m[i] << 14) + len) / (2 * len);
        if (q > 32767) q = 32767;
        r[i] = r[i] < 0 ? -longint'(q) : longint'(q);
      end
      o.tan_x = r[0][15:0];
      o.tan_y = r[1][15:0];
      o.tan_z = r[2][15:0];
      o.used_fallback = 1'b0;
      return o;
    endfunction

    function void note_input(in_item_t it);
      int v;
      v = it.vertex_index;
      case (it.func)
        FUNC_LOAD: begin
          verts[v] = '{it.pos_x, it.pos_y, it.pos_z, it.norm_x, it.norm_y, it.norm_z,
                       it.tex_u, it.tex_v};
          sum_x[v] = 0;
          sum_y[v] = 0;
          sum_z[v] = 0;
        end
        FUNC_TRI:  add_triangle(v, it.corner_b, it.corner_c);
        FUNC_READ: want_q.push_back(finish_tangent(v));
        default: ;
      endcase
    endfunction

    function void report(string what, longint got, longint want);
      $display("tangent error: %s got %0d expected %0d", what, got, want);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      if (want_q.size() == 0) begin
        report("unexpected beat, read_index", got.read_index, -1);
        return;
      end
      w = want_q.pop_front();
      if (got.read_index != w.read_index) report("read_index", got.read_index, w.read_index);
      if (got.tan_x != w.tan_x) report("tan_x", got.tan_x, w.tan_x);
      if (got.tan_y != w.tan_y) report("tan_y", got.tan_y, w.tan_y);
      if (got.tan_z != w.tan_z) report("tan_z", got.tan_z, w.tan_z);
      if (got.used_fallback != w.used_fallback)
        report("used_fallback", got.used_fallback, w.used_fallback);
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic        cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [15:0] cfg_data_i;
  in_item_t    in_i;
  out_item_t   out_o;

  tangent_scoreboard sb = new();

  // Only loaded vertices are ever used as corners or read back.
  bit written[NVERT];
  int loaded_q[$];
  bit no_idle;
  int hold_off;
  int stall_cycles;

  mesh_tangent_generator dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Gap lengths: usually none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Monitor: beats are taken at the rising edge, where the inputs driven at the
  // falling edge are long settled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, and a long hold-off whenever hold_off is set, so
  // that the block backs up and drops in_ready.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off) @(negedge clk_i);
        hold_off = 0;
      end else begin
        int g;
        g = pick_gap();
        if (g > 0) begin
          out_ready_i <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
    end
  end

  // Sender: called at a falling edge, returns at the falling edge after the beat.
  // Valid stays high straight into the next beat when there is no gap.
  task automatic send_beat(in_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    if (it.func == FUNC_LOAD && !written[it.vertex_index]) begin
      written[it.vertex_index] = 1'b1;
      loaded_q.push_back(it.vertex_index);
    end
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every read to come back, then long enough for a triangle that
  // produces no beat to finish before the thresholds change.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.want_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic in_item_t load_item(int v, longint px, longint py, longint pz,
                                         int nx, int ny, int nz, int u, int w);
    in_item_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.vertex_index = v;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.norm_x = nx;
    it.norm_y = ny;
    it.norm_z = nz;
    it.tex_u = u;
    it.tex_v = w;
    return it;
  endfunction

  function automatic in_item_t op_item(logic [1:0] f, int a, int b, int c);
    in_item_t it;
    it = '0;
    it.func = f;
    it.vertex_index = a;
    it.corner_b = b;
    it.corner_c = c;
    return it;
  endfunction

  function automatic int pick_loaded();
    return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
  endfunction

  // Random beat: loads mostly land in a small pool so that triangles pile up
  // on the vertices that get read; positions are mostly modest with some full
  // range to push the sums into saturation.
  function automatic in_item_t random_item();
    in_item_t it;
    int r, v;
    r = $urandom_range(0, 99);
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (r < 25 || loaded_q.size() < 3) begin
      it.func = FUNC_LOAD;
      v = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 47) : $urandom_range(0, NVERT - 1);
      it.vertex_index = v;
      if ($urandom_range(0, 3) != 0) begin
        it.pos_x = $signed(17'($urandom));
        it.pos_y = $signed(17'($urandom));
        it.pos_z = $signed(17'($urandom));
      end
    end else if (r < 70) begin
      it.func = FUNC_TRI;
      it.vertex_index = pick_loaded();
      it.corner_b = pick_loaded();
      it.corner_c = pick_loaded();
    end else if (r < 96) begin
      it.func = FUNC_READ;
      it.vertex_index = pick_loaded();
    end else begin
      it.func = FUNC_NOP;
    end
    return it;
  endfunction

  initial begin
    logic [15:0] det_set[6];
    logic [15:0] len_set[6];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DET_THR;
    cfg_data_i = '0;
    no_idle = 1'b0;
    hold_off = 0;
    stall_cycles = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset thresholds. A tangent along x on a vertex
    // whose normal is x leaves nothing after the normal is taken out, so that
    // read falls back; a freshly loaded vertex falls back on length.
    send_beat(load_item(0, 0, 0, 0, 16384, 0, 0, 0, 0));
    send_beat(load_item(1, 4096, 0, 0, 0, 0, 16384, 16384, 0));
    send_beat(load_item(2, 0, 4096, 0, 0, 0, 16384, 0, 16384));
    send_beat(load_item(1023, 8388607, -8388608, 8388607, 32767, -32768, 32767,
                        32767, -32768));
    send_beat(load_item(512, -8388608, 8388607, -8388608, -32768, 32767, -32768,
                        -32768, 32767));
    send_beat(op_item(FUNC_READ, 0, 0, 0));
    send_beat(op_item(FUNC_TRI, 0, 1, 2));
    send_beat(op_item(FUNC_READ, 0, 0, 0));
    send_beat(op_item(FUNC_READ, 1, 0, 0));
    send_beat(op_item(FUNC_READ, 2, 0, 0));
    send_beat(op_item(FUNC_TRI, 1023, 512, 2));
    send_beat(op_item(FUNC_TRI, 512, 1023, 0));
    send_beat(op_item(FUNC_TRI, 0, 0, 1));
    send_beat(op_item(FUNC_NOP, 1023, 1023, 1023));
    send_beat(op_item(FUNC_READ, 1023, 0, 0));
    send_beat(op_item(FUNC_READ, 512, 0, 0));
    send_beat('1 & ~in_item_t'({2'b00, {(34 + 72 + 80){1'b0}}}) | op_item(FUNC_NOP, 0, 0, 0));
    drain();

    // Threshold phases, extremes included; one phase runs with no idling and one
    // holds the receiver off while reads keep arriving.
    det_set = '{16'd0, 16'd65535, 16'd268, 16'd1000, 16'd0, 16'd12345};
    len_set = '{16'd0, 16'd65535, 16'd300, 16'd0, 16'd4096, 16'd1};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_DET_THR, det_set[ph]);
      write_reg(CFG_LEN_THR, len_set[ph]);
      no_idle = (ph == 2);
      if (ph == 3) begin
        hold_off = 600;
        for (int k = 0; k < 10; k++)
          send_beat(op_item(FUNC_READ, pick_loaded(), $urandom, $urandom));
      end
      repeat (255) send_beat(random_item());
      drain();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
